// ===== rtl/ordered_array_list_engine_top_assert.svh =====
// Assertion macros used by the ordered array list engine top level.
`ifndef ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define OAL_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("oal: invariant violated");

`define OAL_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("oal: same-cycle implication violated");

`define OAL_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("oal: next-cycle implication violated");

`else

`define OAL_ASSERT(lbl, cond)
`define OAL_ASSERT_IMP(lbl, pre, post)
`define OAL_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ===== rtl/oal_pkg.sv =====
// Package with sizes, types and codes of the ordered array list engine.
`default_nettype none

package oal_pkg;

    localparam int DEPTH   = 64;
    localparam int KEY_W   = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 7;
    localparam int OIDX_W  = 6;
    localparam int OCNT_W  = 7;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP     = 8;
    localparam int GIDX_W  = $clog2(GRP);
    localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
    localparam int NGIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int TOT     = NGRP * GRP;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_SEARCH = 3'd2,
        KIND_READ   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_SEL,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        LK_NONE,
        LK_KEY,
        LK_POS
    } lookup_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        key_t              key;
        logic [POS_W-1:0]  position;
    } oal_in_t;

    typedef struct packed {
        logic              ok;
        logic [OIDX_W-1:0] index;
        key_t              value;
        logic [OCNT_W-1:0] count;
        key_t              first_key;
        key_t              last_key;
    } oal_out_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        lookup_mode_t     mode;
        key_t             key;
        logic [IDX_W-1:0] pos;
        logic             pos_ok;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] last_idx;
        logic             last_ok;
        logic [IDX_W-1:0] prev_idx;
        logic             prev_ok;
        logic             ins_en;
        logic             del_en;
        logic [IDX_W-1:0] where;
    } cell_ctl_t;

    // Registered match flags of one cell.
    typedef struct packed {
        logic hit;
        logic hit_last;
        logic hit_prev;
    } cell_tap_t;

    // Result of the reduction tree.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        key_t             val;
        key_t             last_val;
        key_t             prev_val;
    } sel_t;

endpackage

`default_nettype wire

// ===== rtl/oal_cell.sv =====
// One list cell: holds an entry, compares it and shifts with its neighbors.
`default_nettype none

module oal_cell (
    input  wire                           clk,
    input  oal_pkg::cell_ctl_t            ctl,
    input  wire  [oal_pkg::IDX_W-1:0]     id,
    input  oal_pkg::key_t                 left,
    input  oal_pkg::key_t                 right,
    output oal_pkg::key_t                 value,
    output oal_pkg::cell_tap_t            tap
);
    import oal_pkg::*;

    key_t             value_reg;
    key_t             value_next;
    cell_tap_t        tap_reg;
    cell_tap_t        tap_next;
    logic [CNT_W-1:0] id_ext;
    logic             in_list;

    assign id_ext  = CNT_W'(id);
    assign in_list = id_ext < ctl.count;

    always_comb
    begin
        tap_next.hit_last = ctl.last_ok && (id == ctl.last_idx);
        tap_next.hit_prev = ctl.prev_ok && (id == ctl.prev_idx);
        case (ctl.mode)
            LK_KEY:  tap_next.hit = in_list && (value_reg == ctl.key);
            LK_POS:  tap_next.hit = ctl.pos_ok && (id == ctl.pos);
            default: tap_next.hit = 1'b0;
        endcase
    end

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins_en)
        begin
            if (id == ctl.pos)
            begin
                value_next = ctl.key;
            end
            else if ((id > ctl.pos) && (id_ext <= ctl.count))
            begin
                value_next = left;
            end
        end
        else if (ctl.del_en)
        begin
            if ((id >= ctl.where) && ((id_ext + CNT_W'(1)) < ctl.count))
            begin
                value_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tap_reg   <= tap_next;
    end

    assign value = value_reg;
    assign tap   = tap_reg;

endmodule

`default_nettype wire

// ===== rtl/oal_reduce.sv =====
// Two-level registered tree that picks the first hit and the tail entries.
`default_nettype none

module oal_reduce (
    input  wire                                         clk,
    input  oal_pkg::cell_tap_t [oal_pkg::DEPTH-1:0]     taps,
    input  wire  [oal_pkg::DEPTH-1:0][oal_pkg::KEY_W-1:0] vals,
    output oal_pkg::sel_t                               sel
);
    import oal_pkg::*;

    cell_tap_t [TOT-1:0]              tap_pad;
    logic      [TOT-1:0][KEY_W-1:0]   val_pad;

    logic [NGRP-1:0]                  grp_hit_next;
    logic [NGRP-1:0][GIDX_W-1:0]      grp_lidx_next;
    logic [NGRP-1:0][KEY_W-1:0]       grp_val_next;
    logic [NGRP-1:0][KEY_W-1:0]       grp_last_next;
    logic [NGRP-1:0][KEY_W-1:0]       grp_prev_next;
    logic [NGRP-1:0]                  grp_hit_reg;
    logic [NGRP-1:0][GIDX_W-1:0]      grp_lidx_reg;
    logic [NGRP-1:0][KEY_W-1:0]       grp_val_reg;
    logic [NGRP-1:0][KEY_W-1:0]       grp_last_reg;
    logic [NGRP-1:0][KEY_W-1:0]       grp_prev_reg;

    sel_t sel_next;
    sel_t sel_reg;

    genvar c;
    genvar g;

    generate
        for (c = 0; c < TOT; c++)
        begin : g_pad
            if (c < DEPTH)
            begin : g_real
                assign tap_pad[c] = taps[c];
                assign val_pad[c] = vals[c];
            end
            else
            begin : g_fill
                assign tap_pad[c] = '0;
                assign val_pad[c] = '0;
            end
        end

        for (g = 0; g < NGRP; g++)
        begin : g_group
            always_comb
            begin
                grp_hit_next[g]  = 1'b0;
                grp_lidx_next[g] = '0;
                grp_val_next[g]  = '0;
                grp_last_next[g] = '0;
                grp_prev_next[g] = '0;
                // Walk downward so the lowest hit wins.
                for (int j = GRP - 1; j >= 0; j--)
                begin
                    if (tap_pad[g*GRP + j].hit)
                    begin
                        grp_hit_next[g]  = 1'b1;
                        grp_lidx_next[g] = GIDX_W'(j);
                        grp_val_next[g]  = val_pad[g*GRP + j];
                    end
                    if (tap_pad[g*GRP + j].hit_last)
                    begin
                        grp_last_next[g] = grp_last_next[g] | val_pad[g*GRP + j];
                    end
                    if (tap_pad[g*GRP + j].hit_prev)
                    begin
                        grp_prev_next[g] = grp_prev_next[g] | val_pad[g*GRP + j];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        grp_hit_reg  <= grp_hit_next;
        grp_lidx_reg <= grp_lidx_next;
        grp_val_reg  <= grp_val_next;
        grp_last_reg <= grp_last_next;
        grp_prev_reg <= grp_prev_next;
    end

    always_comb
    begin
        sel_next = '0;
        for (int k = NGRP - 1; k >= 0; k--)
        begin
            if (grp_hit_reg[k])
            begin
                sel_next.found = 1'b1;
                sel_next.idx   = IDX_W'({NGIDX_W'(k), grp_lidx_reg[k]});
                sel_next.val   = grp_val_reg[k];
            end
            sel_next.last_val = sel_next.last_val | grp_last_reg[k];
            sel_next.prev_val = sel_next.prev_val | grp_prev_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign sel = sel_reg;

endmodule

`default_nettype wire

// ===== rtl/ordered_array_list_engine_top.sv =====
// Top level of the ordered array list engine: controller and cell row.
//
// Usage: the block keeps an ordered list of up to DEPTH signed 32-bit keys.
// An input beat on in_data carries kind, key and position; it is taken at a
// rising edge with in_valid high and in_stall low. Each input beat yields
// exactly one output beat on out_data, taken when out_valid is high and
// out_stall is low.
// From the input beat to out_valid, the cells compare and register their
// match flags, the hit reduction tree registers its group results and then
// its selection, and the cells shift while the output register loads.
// One item is in flight at a time: no new input beat is taken until the
// current item has been applied and the controller is back in idle;
// in_stall is high while an item is in flight.
// A new input beat is taken while an earlier result still waits in the
// output register. If that result is still stalled when the next one is
// ready, the controller holds the item and the list unchanged until the
// output register frees up.
// Reset empties the list at once (count zero) and drops any pending output;
// the entry storage itself is not cleared.
`default_nettype none
`include "ordered_array_list_engine_top_assert.svh"

module ordered_array_list_engine_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  oal_pkg::oal_in_t    in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output oal_pkg::oal_out_t   out_data
);
    import oal_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    oal_in_t          op_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    oal_out_t         out_reg;
    oal_out_t         out_next;

    cell_ctl_t                      ctl;
    cell_tap_t [DEPTH-1:0]          taps;
    logic [DEPTH-1:0][KEY_W-1:0]    cell_val;
    sel_t                           sel;

    logic             in_fire;
    logic             apply_fire;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             ins_ok;
    logic             del_ok;
    logic             pos_rd_ok;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    key_t             cell0_val;
    key_t             cell1_val;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign apply_fire = (state_reg == S_APPLY) && !(out_valid_reg && out_stall);

    assign pos_ext   = CMP_W'(op_reg.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_rd_ok = pos_ext < cnt_ext;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign ins_ok    = (op_reg.kind == KIND_INSERT) && (count_reg < CNT_W'(DEPTH))
                       && (pos_ext <= cnt_ext);
    assign del_ok    = (op_reg.kind == KIND_DELETE) && sel.found;
    assign cell0_val = cell_val[0];
    assign cell1_val = cell_val[1];

    always_comb
    begin
        case (op_reg.kind)
            KIND_SEARCH: ctl.mode = LK_KEY;
            KIND_DELETE: ctl.mode = LK_KEY;
            KIND_READ:   ctl.mode = LK_POS;
            default:     ctl.mode = LK_NONE;
        endcase
        ctl.key      = op_reg.key;
        ctl.pos      = IDX_W'(op_reg.position);
        ctl.pos_ok   = pos_rd_ok;
        ctl.count    = count_reg;
        ctl.last_idx = IDX_W'(cnt_m1);
        ctl.last_ok  = (count_reg != '0);
        ctl.prev_idx = IDX_W'(cnt_m2);
        ctl.prev_ok  = (count_reg >= CNT_W'(2));
        ctl.ins_en   = apply_fire && ins_ok;
        ctl.del_en   = apply_fire && del_ok;
        ctl.where    = sel.idx;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            key_t cell_left;
            key_t cell_right;
            key_t cell_out;

            if (i == 0)
            begin : g_head
                assign cell_left = '0;
            end
            else
            begin : g_body_l
                assign cell_left = cell_val[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign cell_right = '0;
            end
            else
            begin : g_body_r
                assign cell_right = cell_val[i+1];
            end

            oal_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .id    (IDX_W'(i)),
                .left  (cell_left),
                .right (cell_right),
                .value (cell_out),
                .tap   (taps[i])
            );

            assign cell_val[i] = cell_out;
        end
    endgenerate

    oal_reduce u_reduce (
        .clk  (clk),
        .taps (taps),
        .vals (cell_val),
        .sel  (sel)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_CMP;
            S_CMP:   state_next = S_GRP;
            S_GRP:   state_next = S_SEL;
            S_SEL:   state_next = S_APPLY;
            S_APPLY: if (apply_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Result assembly; first and last keys are derived from the pre-shift
    // entries so that the output loads in the same cycle as the shift.
    always_comb
    begin
        count_next     = count_reg;
        out_next       = '0;
        case (op_reg.kind)
            KIND_INSERT:
            begin
                out_next.ok = ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE:
            begin
                out_next.ok = sel.found;
                if (sel.found)
                begin
                    count_next = cnt_m1;
                end
            end
            KIND_SEARCH:
            begin
                out_next.ok = sel.found;
                if (sel.found)
                begin
                    out_next.index = OIDX_W'(sel.idx);
                end
            end
            KIND_READ:
            begin
                out_next.ok = sel.found;
                if (sel.found)
                begin
                    out_next.value = sel.val;
                end
            end
            KIND_CLEAR:
            begin
                out_next.ok = 1'b1;
                count_next  = '0;
            end
            default:
            begin
                out_next.ok = 1'b0;
            end
        endcase

        out_next.count = OCNT_W'(count_next);

        if (count_next != '0)
        begin
            if (ins_ok && (op_reg.position == '0))
            begin
                out_next.first_key = op_reg.key;
            end
            else if (del_ok && (sel.idx == '0))
            begin
                out_next.first_key = cell1_val;
            end
            else
            begin
                out_next.first_key = cell0_val;
            end

            if (ins_ok && (pos_ext == cnt_ext))
            begin
                out_next.last_key = op_reg.key;
            end
            else if (del_ok && (CNT_W'(sel.idx) == cnt_m1))
            begin
                out_next.last_key = sel.prev_val;
            end
            else
            begin
                out_next.last_key = sel.last_val;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (apply_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= in_data;
        end
        if (apply_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `OAL_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `OAL_ASSERT_NXT(a_accept_starts, in_fire, state_reg == S_CMP)
    `OAL_ASSERT_NXT(a_apply_loads_out, apply_fire, out_valid_reg)
    `OAL_ASSERT_NXT(a_hold_when_blocked,
        (state_reg == S_APPLY) && out_valid_reg && out_stall,
        (state_reg == S_APPLY) && $stable(count_reg))
    `OAL_ASSERT_NXT(a_delete_shrinks, apply_fire && del_ok,
        (count_reg + CNT_W'(1)) == $past(count_reg))

endmodule

`default_nettype wire
